// ===== rtl/tts_pkg.sv =====
// Package for the typed timeout slot table: slot count, field widths,
// command and status codes. Depends on nothing; every other file uses it.
package tts_pkg;

  // Table size and the index width that follows from it.
  localparam int SLOT_COUNT = 4;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths of the command and result words.
  localparam int CMD_W = 3;
  localparam int KIND_W = 3;
  localparam int DELAY_W = 32;
  localparam int STATUS_W = 2;
  localparam int KIND_MASK_W = 6;

  // Highest real timeout kind; kind zero means none.
  localparam logic [KIND_W-1:0] KIND_NONE = '0;
  localparam logic [KIND_W-1:0] KIND_MAX = 3'd5;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_SET       = 3'd0,
    CMD_CLEAR     = 3'd1,
    CMD_CHECK     = 3'd2,
    CMD_RESET_ALL = 3'd3,
    CMD_TICK      = 3'd4
  } cmd_t;

  // Result codes of a set command.
  typedef enum logic [STATUS_W-1:0] {
    SET_ARMED   = 2'd0,
    SET_HELD    = 2'd1,
    SET_NO_FREE = 2'd2
  } set_status_t;

endpackage

// ===== rtl/tts_if.sv =====
// Valid/ready channels of the typed timeout slot table: the command word
// channel and the result word channel. Depends on tts_pkg.
interface tts_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tts_pkg::CMD_W-1:0]     command;
  tts_pkg::kind_t                timeout_kind;
  tts_pkg::delay_t               delay_ticks;

  modport source (output valid, command, timeout_kind, delay_ticks, input ready);
  modport sink (input valid, command, timeout_kind, delay_ticks, output ready);
endinterface

interface tts_res_if;
  logic                               valid;
  logic                               ready;
  logic [tts_pkg::STATUS_W-1:0]       set_status;
  logic                               is_expired;
  logic                               was_held;
  logic [tts_pkg::KIND_MASK_W-1:0]    expired_kinds;

  modport source (output valid, set_status, is_expired, was_held, expired_kinds,
                  input ready);
  modport sink (input valid, set_status, is_expired, was_held, expired_kinds,
                output ready);
endinterface

// ===== rtl/typed_timeout_slot_table.sv =====
// Typed timeout slot table: a few one-shot timeout slots, each owned by one
// timeout kind, armed by set, counted down by tick, freed by check, clear or reset-all.
// Depends on tts_pkg and on the channel interfaces in tts_if.sv.
//
// Usage:
//   cmd_ch carries one command word (command, timeout_kind, delay_ticks);
//   res_ch returns exactly one result word for every command word, in order.
//   A command word is taken into an input register, decoded against the slot
//   table, and its result lands in the output register while the slot table
//   is updated at the same edge. One command word is taken every cycle while
//   the receiver does not stall, with all slots compared and counted down in
//   parallel.
//   When the receiver stalls the result word holds in the output register; the
//   input register still takes one more word, then cmd_ch.ready drops until
//   the result is taken.
//   Synchronous reset frees every slot and empties both registers; the block
//   is ready for a command word as soon as reset is released.
module typed_timeout_slot_table (
  input  logic clk,
  input  logic rst,
  tts_cmd_if.sink   cmd_ch,
  tts_res_if.source res_ch
);

  // Input register.
  logic                        stg_valid;
  logic [tts_pkg::CMD_W-1:0]   stg_command;
  tts_pkg::kind_t              stg_kind;
  tts_pkg::delay_t             stg_delay;

  // Slot table.
  tts_pkg::kind_t  slot_owner [tts_pkg::SLOT_COUNT];
  logic            slot_done [tts_pkg::SLOT_COUNT];
  tts_pkg::delay_t slot_remaining [tts_pkg::SLOT_COUNT];

  tts_pkg::kind_t  slot_owner_next [tts_pkg::SLOT_COUNT];
  logic            slot_done_next [tts_pkg::SLOT_COUNT];
  tts_pkg::delay_t slot_remaining_next [tts_pkg::SLOT_COUNT];

  // Decode results.
  logic                             kind_ok;
  logic                             hit_found;
  tts_pkg::slot_idx_t               hit_idx;
  logic                             free_found;
  tts_pkg::slot_idx_t               free_idx;
  logic [tts_pkg::STATUS_W-1:0]     status_next;
  logic                             expired_next;
  logic [tts_pkg::KIND_MASK_W-1:0]  mask_next;

  logic stg_adv;

  // The stage advances when the output register is empty or being emptied.
  assign stg_adv = stg_valid && (!res_ch.valid || res_ch.ready);
  assign cmd_ch.ready = !stg_valid || stg_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      stg_valid <= cmd_ch.valid;
    end
    if (cmd_ch.valid && cmd_ch.ready) begin
      stg_command <= cmd_ch.command;
      stg_kind    <= cmd_ch.timeout_kind;
      stg_delay   <= cmd_ch.delay_ticks;
    end
  end

  // Look up the addressed kind and the lowest free slot.
  always_comb begin
    kind_ok    = (stg_kind != tts_pkg::KIND_NONE) && (stg_kind <= tts_pkg::KIND_MAX);
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = tts_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (kind_ok && (slot_owner[i] == stg_kind)) begin
        hit_found = 1'b1;
        hit_idx   = tts_pkg::SLOT_IDX_W'(i);
      end
      if (slot_owner[i] == tts_pkg::KIND_NONE) begin
        free_found = 1'b1;
        free_idx   = tts_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  // Command execution: next slot table and result fields.
  always_comb begin
    for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
      slot_owner_next[i]     = slot_owner[i];
      slot_done_next[i]      = slot_done[i];
      slot_remaining_next[i] = slot_remaining[i];
    end
    status_next  = tts_pkg::SET_ARMED;
    expired_next = 1'b0;
    mask_next    = '0;

    case (stg_command)
      tts_pkg::CMD_SET: begin
        if (!kind_ok) begin
          status_next = tts_pkg::SET_NO_FREE;
        end else if (hit_found) begin
          status_next = tts_pkg::SET_HELD;
        end else if (free_found) begin
          slot_owner_next[free_idx]     = stg_kind;
          slot_done_next[free_idx]      = 1'b0;
          slot_remaining_next[free_idx] = stg_delay;
          status_next = tts_pkg::SET_ARMED;
        end else begin
          status_next = tts_pkg::SET_NO_FREE;
        end
      end
      tts_pkg::CMD_CLEAR: begin
        if (hit_found) begin
          slot_owner_next[hit_idx]     = tts_pkg::KIND_NONE;
          slot_done_next[hit_idx]      = 1'b0;
          slot_remaining_next[hit_idx] = '0;
        end
      end
      tts_pkg::CMD_CHECK: begin
        if (hit_found && slot_done[hit_idx]) begin
          expired_next = 1'b1;
          slot_owner_next[hit_idx]     = tts_pkg::KIND_NONE;
          slot_done_next[hit_idx]      = 1'b0;
          slot_remaining_next[hit_idx] = '0;
        end
      end
      tts_pkg::CMD_RESET_ALL: begin
        for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
          slot_owner_next[i]     = tts_pkg::KIND_NONE;
          slot_done_next[i]      = 1'b0;
          slot_remaining_next[i] = '0;
        end
      end
      tts_pkg::CMD_TICK: begin
        // Every armed slot that has not yet expired counts down in parallel.
        for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
          if ((slot_owner[i] != tts_pkg::KIND_NONE) && !slot_done[i]) begin
            if (slot_remaining[i] <= tts_pkg::DELAY_W'(1)) begin
              slot_remaining_next[i] = '0;
              slot_done_next[i]      = 1'b1;
              mask_next = mask_next | (tts_pkg::KIND_MASK_W'(1) << slot_owner[i]);
            end else begin
              slot_remaining_next[i] = slot_remaining[i] - tts_pkg::DELAY_W'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Slot table update, one command word per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
        slot_owner[i]     <= tts_pkg::KIND_NONE;
        slot_done[i]      <= 1'b0;
        slot_remaining[i] <= '0;
      end
    end else if (stg_adv) begin
      for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
        slot_owner[i]     <= slot_owner_next[i];
        slot_done[i]      <= slot_done_next[i];
        slot_remaining[i] <= slot_remaining_next[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_ch.valid <= 1'b0;
    end else if (stg_adv) begin
      res_ch.valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_ch.valid <= 1'b0;
    end
    if (stg_adv) begin
      res_ch.set_status    <= status_next;
      res_ch.is_expired    <= expired_next;
      res_ch.was_held      <= hit_found;
      res_ch.expired_kinds <= mask_next;
    end
  end

endmodule
